// ===== rtl/wstfm_pkg.sv =====
// shared types, constants and header byte functions for the websocket text frame masker
// no dependencies; imported by every module of the block but the checker
`default_nettype none

package wstfm_pkg;

    localparam int LEN_BITS    = 63;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    localparam logic [7:0] HDR_FIN_TEXT  = 8'h81;
    localparam logic [7:0] MASK_BIT      = 8'h80;
    localparam logic [7:0] SHORT_MAX_LEN = 8'd125;
    localparam logic [6:0] CODE_MID      = 7'd126;
    localparam logic [6:0] CODE_LONG     = 7'd127;

    typedef enum logic [1:0] {
        HDR_SHORT,
        HDR_MID,
        HDR_LONG
    } hdr_kind_t;

    // one queue entry: either a whole header burst or one masked payload byte
    typedef struct packed {
        logic                is_data;
        hdr_kind_t           hdr;
        logic                empty;
        logic [LEN_BITS-1:0] len;
        logic [31:0]         key;
        logic [7:0]          data;
        logic                last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // index of the final header byte
    function automatic logic [3:0] hdr_end_idx(input hdr_kind_t kind);
        logic [3:0] r;
        unique case (kind)
            HDR_SHORT: r = 4'd5;
            HDR_MID:   r = 4'd7;
            HDR_LONG:  r = 4'd13;
            default:   r = 4'd5;
        endcase
        return r;
    endfunction

    // index of the first key byte
    function automatic logic [3:0] hdr_key_base(input hdr_kind_t kind);
        logic [3:0] r;
        unique case (kind)
            HDR_SHORT: r = 4'd2;
            HDR_MID:   r = 4'd4;
            HDR_LONG:  r = 4'd10;
            default:   r = 4'd2;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hdr_byte(input entry_t e, input logic [3:0] idx);
        logic [63:0] len64;
        logic [3:0]  base;
        logic [3:0]  koff;
        logic [3:0]  loff;
        logic [31:0] kshift;
        logic [63:0] lshift;
        logic [7:0]  r;
        len64  = 64'(e.len);
        base   = hdr_key_base(e.hdr);
        koff   = idx - base;
        loff   = base - 4'd1 - idx;
        kshift = e.key >> {koff[1:0], 3'b000};
        lshift = len64 >> {loff[2:0], 3'b000};
        if (idx == 4'd0) begin
            r = HDR_FIN_TEXT;
        end else if (idx >= base) begin
            r = kshift[7:0];
        end else if (idx == 4'd1) begin
            unique case (e.hdr)
                HDR_SHORT: r = MASK_BIT | {1'b0, e.len[6:0]};
                HDR_MID:   r = MASK_BIT | {1'b0, CODE_MID};
                HDR_LONG:  r = MASK_BIT | {1'b0, CODE_LONG};
                default:   r = MASK_BIT;
            endcase
        end else begin
            // length bytes, most significant first
            r = lshift[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wstfm_queue.sv =====
// four-entry item queue between the front and back parts of the frame masker
// depends on wstfm_pkg
`default_nettype none

module wstfm_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire wstfm_pkg::entry_t  push_entry,
    input  wire logic               pop,
    output wstfm_pkg::entry_t       head,
    output wstfm_pkg::q_status_t    status
);
    import wstfm_pkg::*;

    entry_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign status  = '{full:  (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH)),
                       empty: (count_reg == '0)};
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wstfm_front.sv =====
// front part of the frame masker: accepts items, keeps frame state, masks payload
// bytes and classifies start items by header length; depends on wstfm_pkg
`default_nettype none

module wstfm_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_cmd,
    input  wire logic [wstfm_pkg::LEN_BITS-1:0] s_payload_len,
    input  wire logic [31:0]                    s_mask_key,
    input  wire logic [7:0]                     s_data_byte,
    input  wire wstfm_pkg::q_status_t           q_status,
    output logic                                push,
    output wstfm_pkg::entry_t                   push_entry
);
    import wstfm_pkg::*;

    logic [LEN_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [31:0]         key_store_reg, key_store_next;
    logic [1:0]          key_phase_reg, key_phase_next;
    logic                frame_open_reg, frame_open_next;

    logic                accept;
    logic [LEN_BITS-1:0] left_dec;
    logic                fin;
    logic [31:0]         key_shift;
    hdr_kind_t           kind;

    assign s_ready   = !q_status.full;
    assign accept    = s_valid && s_ready;
    assign left_dec  = bytes_left_reg - 1'b1;
    assign fin       = (left_dec == '0);
    assign key_shift = key_store_reg >> {key_phase_reg, 3'b000};

    always_comb begin
        priority if (s_payload_len <= LEN_BITS'(SHORT_MAX_LEN)) begin
            kind = HDR_SHORT;
        end else if ((s_payload_len >> 16) == '0) begin
            kind = HDR_MID;
        end else begin
            kind = HDR_LONG;
        end
    end

    always_comb begin
        bytes_left_next = bytes_left_reg;
        key_store_next  = key_store_reg;
        key_phase_next  = key_phase_reg;
        frame_open_next = frame_open_reg;
        push            = 1'b0;
        push_entry.is_data = (s_cmd == CMD_BYTE);
        push_entry.hdr     = kind;
        push_entry.empty   = (s_payload_len == '0);
        push_entry.len     = s_payload_len;
        push_entry.key     = s_mask_key;
        push_entry.data    = s_data_byte ^ key_shift[7:0];
        push_entry.last    = fin;
        if (accept) begin
            if (s_cmd == CMD_START) begin
                // a start abandons whatever frame is open
                push            = 1'b1;
                bytes_left_next = s_payload_len;
                key_store_next  = s_mask_key;
                key_phase_next  = 2'd0;
                frame_open_next = (s_payload_len != '0);
            end else if (frame_open_reg) begin
                push            = 1'b1;
                bytes_left_next = left_dec;
                key_phase_next  = key_phase_reg + 2'd1;
                frame_open_next = !fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            key_store_reg  <= '0;
            key_phase_reg  <= '0;
            frame_open_reg <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            key_store_reg  <= key_store_next;
            key_phase_reg  <= key_phase_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wstfm_back.sv =====
// back part of the frame masker: plays header bursts and payload bytes from the
// queue into the output register; depends on wstfm_pkg
`default_nettype none

module wstfm_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire wstfm_pkg::entry_t     head,
    input  wire wstfm_pkg::q_status_t  q_status,
    output logic                       pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_last
);
    import wstfm_pkg::*;

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       emit;
    logic       hdr_done;
    logic [3:0] end_idx;
    logic [7:0] byte_sel;
    logic       last_sel;

    assign end_idx  = hdr_end_idx(head.hdr);
    assign hdr_done = (idx_reg == end_idx);
    assign emit     = !q_status.empty && (!valid_reg || m_ready);

    always_comb begin
        if (head.is_data) begin
            byte_sel = head.data;
            last_sel = head.last;
            pop      = emit;
            idx_next = idx_reg;
        end else begin
            byte_sel = hdr_byte(head, idx_reg);
            last_sel = head.empty && hdr_done;
            pop      = emit && hdr_done;
            idx_next = idx_reg;
            if (emit) begin
                idx_next = hdr_done ? 4'd0 : idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= byte_sel;
            last_reg <= last_sel;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_last     = last_reg;

endmodule

`default_nettype wire

// ===== rtl/websocket_text_frame_masker.sv =====
// Masked websocket text frame encoder producing one wire byte per output item.
//
// Input channel (s_*): a start item (s_cmd = 0) carries s_payload_len and
// s_mask_key and produces the header burst 0x81, the mask bit with the length
// code (one, three or nine bytes), then the four key bytes, bits 7:0 first.
// A payload item (s_cmd = 1) produces s_data_byte xored with the next key byte;
// the final payload byte carries m_last. A payload item with no open frame is
// dropped, and a start abandons any open frame. An empty frame ends on its
// last key byte with m_last set.
// Output channel (m_*): one byte and its last flag per item.
// An accepted item passes through the queue into the output register.
// Throughput: one payload item per cycle while the queue is not full; a start
// plays a 6, 8 or 14 byte header from the back part's sequencer. A four-item
// queue between front and back absorbs a header burst while the input runs on.
// Reset (aresetn low, synchronous) empties the queue, closes any open frame
// and drops m_valid. When the receiver stalls the output byte holds, the queue
// fills and s_ready falls once four items are waiting.
// depends on wstfm_pkg, wstfm_front, wstfm_queue, wstfm_back
`default_nettype none

module websocket_text_frame_masker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_cmd,
    input  wire logic [wstfm_pkg::LEN_BITS-1:0] s_payload_len,
    input  wire logic [31:0]                    s_mask_key,
    input  wire logic [7:0]                     s_data_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_last
);
    import wstfm_pkg::*;

    entry_t    push_entry;
    entry_t    head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    wstfm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_payload_len (s_payload_len),
        .s_mask_key    (s_mask_key),
        .s_data_byte   (s_data_byte),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    wstfm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    wstfm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

// ===== rtl/wstfm_checker.sv =====
// port-level checks on the output byte stream of the frame masker, bound to the top level
// no package dependency
`default_nettype none

module wstfm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_last
);

    logic after_last_reg;
    logic second_hdr_reg;

    // track frame boundaries on the output side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_last_reg <= 1'b1;
            second_hdr_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            after_last_reg <= m_last;
            second_hdr_reg <= after_last_reg;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last))
        else $error("stalled output item changed");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && after_last_reg |-> m_out_byte == 8'h81 && !m_last)
        else $error("frame does not open with fin text byte");

    a_mask_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && second_hdr_reg |-> m_out_byte[7] && !m_last)
        else $error("second header byte lacks mask bit");

endmodule

bind websocket_text_frame_masker wstfm_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_last     (m_last)
);

`default_nettype wire
